// ===== sv/tds_pkg.sv =====
package tds_pkg;
    localparam int MaxRowsDefault = 64;
    localparam int DataW = 32;
    localparam int IdxW = 6;

    typedef struct packed {
        logic load_row;
        logic start_row;
        logic div_super;
        logic div_rhs;
        logic back_first;
        logic back_step;
        logic clear_run;
    } tds_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic back_done;
        logic solve_now;
        logic is_row0;
    } tds_sts_t;

    // saturate a 48 bit signed value to 32 bits
    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647) r = 32'sh7fffffff;
        else if (v < -48'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction
endpackage

// ===== sv/tridiagonal_system_solver.sv =====
// channel | valid   | ready   | payload
// input   | s_valid | s_ready | s_sub_diag s_main_diag s_super_diag s_rhs_value s_row_is_last
// result  | m_valid | m_ready | m_solution m_row_index m_last_result m_singular
// each row: accept, form the pivot (ram read, multiply, subtract), then two divisions and a check
// a solve then gives one result at a time, each held until m_ready takes it
// reset is synchronous active low; stores need no clearing
// input is held off while a solve emits results
module tridiagonal_system_solver #(
    parameter int MaxRows = tds_pkg::MaxRowsDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_sub_diag,
    input  logic signed [31:0] s_main_diag,
    input  logic signed [31:0] s_super_diag,
    input  logic signed [31:0] s_rhs_value,
    input  logic               s_row_is_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_solution,
    output logic [5:0]         m_row_index,
    output logic               m_last_result,
    output logic               m_singular
);
    import tds_pkg::*;
    tds_cmd_t cmd;
    tds_sts_t sts;

    tds_controller u_ctrl (.aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .cmd, .sts);
    tds_datapath #(.MaxRows(MaxRows)) u_dp (.aclk, .aresetn, .cmd, .sts,
        .s_sub_diag, .s_main_diag, .s_super_diag, .s_rhs_value, .s_row_is_last,
        .m_solution, .m_row_index, .m_last_result, .m_singular);
endmodule

// ===== sv/tds_ram.sv =====
module tds_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== sv/tds_divider.sv =====
module tds_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quot,
    output logic               zero_den
);
    import tds_pkg::*;

    logic [47:0] rem_reg, rem_next;
    logic [47:0] q_reg, q_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic        nsgn_reg, nsgn_next;
    logic        nzero_reg, nzero_next;
    logic        done_reg, done_next;
    logic [48:0] trial;
    logic [48:0] sq;
    logic signed [49:0] sres;

    assign trial = {rem_reg, q_reg[47]} - {17'd0, d_reg};

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_next = rem_reg; q_next = q_reg; d_next = d_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; neg_next = neg_reg; zero_next = zero_reg;
        nsgn_next = nsgn_reg; nzero_next = nzero_reg; done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            q_next = {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
            d_next = den[31] ? 32'(-den) : 32'(den);
            neg_next = num[31] ^ den[31];
            zero_next = (den == 32'sd0);
            nsgn_next = num[31];
            nzero_next = (num == 32'sd0);
            cnt_next = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[48]) begin
                rem_next = trial[47:0];
                q_next = {q_reg[46:0], 1'b1};
            end else begin
                rem_next = {rem_reg[46:0], q_reg[47]};
                q_next = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next; q_reg <= q_next; d_reg <= d_next; neg_reg <= neg_next;
        zero_reg <= zero_next; nsgn_reg <= nsgn_next; nzero_reg <= nzero_next;
    end

    // sign fix, zero divisor result and saturation
    always_comb begin
        sq = {1'b0, q_reg};
        sres = neg_reg ? -$signed({1'b0, sq}) : $signed({1'b0, sq});
        if (zero_reg) begin
            if (nzero_reg) quot = 32'sd0;
            else if (nsgn_reg) quot = 32'sh80000000;
            else quot = 32'sh7fffffff;
        end else if (sres > 50'sd2147483647) quot = 32'sh7fffffff;
        else if (sres < -50'sd2147483648) quot = 32'sh80000000;
        else quot = sres[31:0];
    end
    assign done = done_reg;
    assign zero_den = zero_reg;
endmodule

// ===== sv/tds_datapath.sv =====
module tds_datapath #(
    parameter int MaxRows = tds_pkg::MaxRowsDefault
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tds_pkg::tds_cmd_t              cmd,
    output tds_pkg::tds_sts_t              sts,
    input  logic signed [31:0]             s_sub_diag,
    input  logic signed [31:0]             s_main_diag,
    input  logic signed [31:0]             s_super_diag,
    input  logic signed [31:0]             s_rhs_value,
    input  logic                           s_row_is_last,
    output logic signed [31:0]             m_solution,
    output logic [5:0]                     m_row_index,
    output logic                           m_last_result,
    output logic                           m_singular
);
    import tds_pkg::*;
    localparam int AW = $clog2(MaxRows);

    logic signed [31:0] a_reg, b_reg, c_reg, d_reg, piv_reg, num_reg, x_reg;
    logic               last_reg;
    logic [6:0]         rows_reg;
    logic [AW-1:0]      idx_reg, bk_reg;
    logic               fault_reg;
    logic signed [63:0] p1_reg, p2_reg;
    logic [1:0]         mph_reg;
    logic [1:0]         bph_reg;
    logic               first_reg;
    logic               div_start, div_done, div_zero;
    logic signed [31:0] div_q;
    logic signed [31:0] cs_rd, ds_rd;
    logic [AW-1:0]      rd_addr;
    logic               wr_c, wr_d;
    logic [AW-1:0]      idx_prev;

    assign idx_prev = idx_reg - AW'(1);
    assign rd_addr = (cmd.back_first || cmd.back_step) ? bk_reg : idx_prev;
    assign wr_c = div_done && cmd.div_super;
    assign wr_d = div_done && cmd.div_rhs;

    tds_ram #(.Width(32), .Depth(MaxRows)) u_csup (
        .aclk, .wr_en(wr_c), .wr_addr(idx_reg), .wr_data(div_q),
        .rd_addr, .rd_data(cs_rd));
    tds_ram #(.Width(32), .Depth(MaxRows)) u_drhs (
        .aclk, .wr_en(wr_d), .wr_addr(idx_reg), .wr_data(div_q),
        .rd_addr, .rd_data(ds_rd));

    assign div_start = cmd.div_super ? (mph_reg == 2'd3) : 1'b0;
    tds_divider u_div (
        .aclk, .aresetn,
        .start(div_start || (cmd.div_rhs && mph_reg == 2'd3)),
        .num(cmd.div_super ? c_reg : num_reg), .den(piv_reg),
        .done(div_done), .quot(div_q), .zero_den(div_zero));

    // row capture, pivot and numerator, products after ram read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= '0; fault_reg <= 1'b0; mph_reg <= '0;
        end else begin
            if (cmd.clear_run) begin
                rows_reg <= '0; fault_reg <= 1'b0;
            end
            if (cmd.load_row) mph_reg <= '0;
            else if (cmd.start_row) mph_reg <= (mph_reg == 2'd3) ? mph_reg : mph_reg + 2'd1;
            else if (cmd.div_super || cmd.div_rhs) mph_reg <= div_done ? 2'd3 : 2'd0;
            if (div_done && div_zero) fault_reg <= 1'b1;
            if (wr_d) rows_reg <= rows_reg + 7'd1;
        end
        if (cmd.load_row) begin
            a_reg <= s_sub_diag; b_reg <= s_main_diag; c_reg <= s_super_diag;
            d_reg <= s_rhs_value; last_reg <= s_row_is_last;
            idx_reg <= (rows_reg >= 7'(MaxRows)) ? AW'(MaxRows - 1) : rows_reg[AW-1:0];
        end
        // start_row phases: 0 ram read, 1 multiply, 2 subtract
        if (cmd.start_row) begin
            if (mph_reg == 2'd1) begin
                p1_reg <= 64'(a_reg) * 64'(cs_rd);
                p2_reg <= 64'(a_reg) * 64'(ds_rd);
            end
            if (mph_reg == 2'd2) begin
                if (idx_reg == '0) begin
                    piv_reg <= b_reg; num_reg <= d_reg;
                end else begin
                    piv_reg <= sat48(48'(b_reg) - 48'(p1_reg >>> 16));
                    num_reg <= sat48(48'(d_reg) - 48'(p2_reg >>> 16));
                end
            end
        end
        // back substitution product
        if (cmd.back_step && bph_reg == 2'd1)
            p1_reg <= 64'(cs_rd) * 64'(x_reg);
    end

    // back walk: 0 ram read, 1 multiply, 2 subtract and present
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bph_reg <= '0; first_reg <= 1'b0;
        end else if (cmd.back_first) begin
            bph_reg <= '0; first_reg <= 1'b1;
            bk_reg <= (rows_reg == 7'(MaxRows)) ? AW'(MaxRows - 1)
                                                : rows_reg[AW-1:0] - AW'(1);
        end else if (cmd.back_step) begin
            bph_reg <= bph_reg + 2'd1;
            if (bph_reg == 2'd2) begin
                bph_reg <= '0;
                first_reg <= 1'b0;
                bk_reg <= bk_reg - AW'(1);
            end
        end
        if (cmd.back_step && bph_reg == 2'd2) begin
            if (first_reg) x_reg <= ds_rd;
            else x_reg <= sat48(48'(ds_rd) - 48'(p1_reg >>> 16));
            m_row_index <= 6'(bk_reg);
            m_last_result <= (bk_reg == '0);
        end
    end

    assign m_solution = x_reg;
    assign m_singular = fault_reg;
    assign sts.mul_done = (mph_reg == 2'd3);
    assign sts.div_done = div_done;
    assign sts.back_done = cmd.back_step && (bph_reg == 2'd2);
    assign sts.solve_now = last_reg || (rows_reg == 7'(MaxRows));
    assign sts.is_row0 = (bk_reg == '0);
endmodule

// ===== sv/tds_controller.sv =====
module tds_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output tds_pkg::tds_cmd_t cmd,
    input  tds_pkg::tds_sts_t sts
);
    import tds_pkg::*;
    localparam logic [2:0] ST_IDLE = 3'd0, ST_PREP = 3'd1, ST_DIVC = 3'd2,
                           ST_DIVD = 3'd3, ST_CHK = 3'd4, ST_BACK = 3'd5,
                           ST_OUT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       row0_reg, row0_next;

    // row load, elimination, then the back walk with one result at a time
    always_comb begin
        state_next = state_reg; row0_next = row0_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: if (s_valid) begin
                cmd.load_row = 1'b1; state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.start_row = 1'b1;
                if (sts.mul_done) state_next = ST_DIVC;
            end
            ST_DIVC: begin
                cmd.div_super = 1'b1;
                if (sts.div_done) state_next = ST_DIVD;
            end
            ST_DIVD: begin
                cmd.div_rhs = 1'b1;
                if (sts.div_done) state_next = ST_CHK;
            end
            ST_CHK: begin
                if (sts.solve_now) begin
                    cmd.back_first = 1'b1; state_next = ST_BACK;
                end else state_next = ST_IDLE;
            end
            ST_BACK: begin
                cmd.back_step = 1'b1;
                if (sts.back_done) begin
                    row0_next = sts.is_row0; state_next = ST_OUT;
                end
            end
            ST_OUT: if (m_ready) begin
                if (row0_reg) begin
                    cmd.clear_run = 1'b1; state_next = ST_IDLE;
                end else state_next = ST_BACK;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; row0_reg <= 1'b0;
        end else begin
            state_reg <= state_next; row0_reg <= row0_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    // no input taken while results pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready during output");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_div_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIVC && sts.div_done |=> state_reg == ST_DIVD)
        else $error("divide order");
endmodule
